// File: sv/differential_drive_odometry_assert.svh
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ODO_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("odometry check failed");

// Next-cycle implication, checked outside reset.
`define ODO_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("odometry check failed");

`endif

// File: sv/odo_pkg.sv
package odo_pkg;

    localparam int TURN_UNITS = 92160;
    localparam int HALF_TURN  = TURN_UNITS / 2;
    localparam int QUART_TURN = TURN_UNITS / 4;

    localparam int HD_W    = 20;  // signed width for heading arithmetic
    localparam int Z_W     = 26;  // residual angle, 2^-16 degree units
    localparam int CS_W    = 34;  // cos/sin in Q2.30 with headroom
    localparam int ATAN_LEN = 24;
    localparam int STEP_W  = 5;

    localparam int OPA_W   = 34;
    localparam int CHUNK_W = 17;
    localparam int OPB_W   = CHUNK_W + 1;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 2 * OPA_W;

    localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic valid;
        logic hi;
    } mul_op_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/odo_mul.sv
module odo_mul
    import odo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_op_t                  op,
    input  logic signed [OPA_W-1:0]  a,
    input  logic signed [OPB_W-1:0]  b,
    output logic signed [ACC_W-1:0]  acc
);

    // A full product is built from a low chunk and then a high chunk of b.
    // The product is registered; the accumulate happens in the cycle after.
    mul_op_t                  op_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_next = a * b;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (op_reg.valid)
        begin
            if (op_reg.hi)
                acc_next = acc_reg + (prod_ext <<< CHUNK_W);
            else
                acc_next = prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= '0;
        else
            op_reg <= op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: sv/odo_cordic.sv
module odo_cordic
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [Z_W-1:0]   z_init,
    input  logic                    flip,
    output logic signed [CS_W-1:0]  cos_out,
    output logic signed [CS_W-1:0]  sin_out,
    output logic                    done
);

    // The arctangent table has ATAN_LEN entries; more steps than that behave as ATAN_LEN.
    localparam int ROT_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic signed [CS_W-1:0] cx_reg, cx_next;
    logic signed [CS_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   flip_reg;
    logic signed [CS_W-1:0] dx, dy;
    logic                   last_step;

    assign dx        = cy_reg >>> step_reg;
    assign dy        = cx_reg >>> step_reg;
    assign last_step = (step_reg == STEP_W'(ROT_STEPS - 1));

    always_comb
    begin
        if (!z_reg[Z_W-1])
        begin
            cx_next = cx_reg - dx;
            cy_next = cy_reg + dy;
            z_next  = z_reg - atan_entry(step_reg);
        end
        else
        begin
            cx_next = cx_reg + dx;
            cy_next = cy_reg - dy;
            z_next  = z_reg + atan_entry(step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg   <= GAIN_Q30;
            cy_reg   <= '0;
            z_reg    <= z_init;
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            z_reg  <= z_next;
        end
    end

    assign cos_out = flip_reg ? -cx_reg : cx_reg;
    assign sin_out = flip_reg ? -cy_reg : cy_reg;
    assign done    = done_reg;

endmodule

// File: sv/differential_drive_odometry.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    encoder sums, gyro heading; kind and flag in s_tuser
// m_*       out        m_tvalid/m_tready    pose x and y
// cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// An odometry sample is worked through the distance multiply, the CORDIC rotation (steps
// beyond 24 count as 24) and the pose multiplies on the shared multiplier, which forms
// each 34 x 34 product from two 34 x 18 partials; s_tready returns after the output state.
// Pose reset and calibrating requests go straight from the idle state to the output state.
// s_tready is high only in the idle state; a result held in the output register
// does not block the next sample, only the write of its own result.
// rst_n clears the pose, the previous distance and the heading offset, and sets the distance scale to 1180.
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // left_position_sum, right_position_sum, gyro_heading, pad
    input  logic [1:0]  s_tuser,   // req_type, calibrating
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pose_x, pose_y
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam logic CFG_HEADING_OFFSET = 1'b0;
    localparam logic CFG_DISTANCE_SCALE = 1'b1;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_PREP     = 14'b00000000000010,
        ST_DIST_LO  = 14'b00000000000100,
        ST_DIST_HI  = 14'b00000000001000,
        ST_DIST_W   = 14'b00000000010000,
        ST_DIST_CHG = 14'b00000000100000,
        ST_ROT_WAIT = 14'b00000001000000,
        ST_X_LO     = 14'b00000010000000,
        ST_X_HI     = 14'b00000100000000,
        ST_Y_LO     = 14'b00001000000000,
        ST_Y_HI     = 14'b00010000000000,
        ST_Y_WAIT   = 14'b00100000000000,
        ST_Y_DONE   = 14'b01000000000000,
        ST_OUT      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0]        heading_offset_reg;
    logic [15:0]        distance_scale_reg;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [31:0] last_dist_reg, last_dist_next;

    logic signed [31:0] left_reg, right_reg;
    logic [16:0]        gyro_reg;
    logic signed [31:0] avg_reg;
    logic [16:0]        head_reg;
    logic signed [32:0] change_reg;

    logic               out_valid_reg;
    logic [31:0]        out_x_reg, out_y_reg;

    logic               s_accept;
    logic               out_load;

    logic signed [32:0]      sum_lr;
    logic signed [HD_W-1:0]  head_raw;
    logic [16:0]             head_norm;
    logic signed [HD_W-1:0]  head_s;
    logic signed [HD_W-1:0]  head_f;
    logic                    flip;
    logic signed [Z_W-1:0]   z_init;

    mul_op_t                 mul_op;
    logic signed [OPA_W-1:0] mul_a;
    logic signed [OPB_W-1:0] mul_b;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] dist_round;
    logic signed [31:0]      scaled_dist;
    logic signed [ACC_W-1:0] delta_round;
    logic signed [37:0]      delta;

    logic                    cor_start;
    logic signed [CS_W-1:0]  cos_v, sin_v;
    logic                    cor_done;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [37:0] d);
        logic signed [38:0] s;
        s = 39'(p) + 39'(d);
        if (s[38:31] != {8{s[38]}})
            return s[38] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Heading (TURN - gyro + start) brought into [0, TURN).
    assign sum_lr   = 33'(left_reg) + 33'(right_reg);
    assign head_raw = HD_W'(TURN_UNITS) + $signed(HD_W'(heading_offset_reg))
                      - $signed(HD_W'(gyro_reg));

    always_comb
    begin
        if (head_raw < 0)
            head_norm = 17'(head_raw + HD_W'(TURN_UNITS));
        else if (head_raw >= HD_W'(2 * TURN_UNITS))
            head_norm = 17'(head_raw - HD_W'(2 * TURN_UNITS));
        else if (head_raw >= HD_W'(TURN_UNITS))
            head_norm = 17'(head_raw - HD_W'(TURN_UNITS));
        else
            head_norm = head_raw[16:0];
    end

    // Fold the heading into [-90, 90] degrees; a half-turn negates the result.
    always_comb
    begin
        head_s = $signed(HD_W'(head_reg));
        if (head_s > HD_W'(HALF_TURN))
            head_s = head_s - HD_W'(TURN_UNITS);
        flip   = 1'b0;
        head_f = head_s;
        if (head_s > HD_W'(QUART_TURN))
        begin
            head_f = head_s - HD_W'(HALF_TURN);
            flip   = 1'b1;
        end
        else if (head_s < -HD_W'(QUART_TURN))
        begin
            head_f = head_s + HD_W'(HALF_TURN);
            flip   = 1'b1;
        end
        z_init = Z_W'(head_f) <<< 8;
    end

    assign cor_start = (state_reg == ST_DIST_LO);

    always_comb
    begin
        mul_op = '0;
        mul_a  = OPA_W'(change_reg);
        mul_b  = '0;
        case (state_reg)
            ST_DIST_LO:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b0};
                mul_a  = OPA_W'(avg_reg);
                mul_b  = OPB_W'(distance_scale_reg);
            end
            ST_DIST_HI:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b1};
                mul_a  = OPA_W'(avg_reg);
            end
            ST_X_LO:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b0};
                mul_b  = $signed({1'b0, cos_v[CHUNK_W-1:0]});
            end
            ST_X_HI:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b1};
                mul_b  = $signed({cos_v[CS_W-1], cos_v[CS_W-1:CHUNK_W]});
            end
            ST_Y_LO:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b0};
                mul_b  = $signed({1'b0, sin_v[CHUNK_W-1:0]});
            end
            ST_Y_HI:
            begin
                mul_op = '{valid: 1'b1, hi: 1'b1};
                mul_b  = $signed({sin_v[CS_W-1], sin_v[CS_W-1:CHUNK_W]});
            end
            default:
            begin
                mul_op = '0;
            end
        endcase
    end

    assign dist_round  = acc + ACC_W'(32'sd32768);
    assign scaled_dist = dist_round[47:16];
    assign delta_round = acc + ACC_W'(64'sd536870912);
    assign delta       = delta_round[ACC_W-1:30];

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        last_dist_next = last_dist_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser[0])
                    begin
                        pos_x_next     = '0;
                        pos_y_next     = '0;
                        last_dist_next = '0;
                        state_next     = ST_OUT;
                    end
                    else if (s_tuser[1])
                        state_next = ST_OUT;
                    else
                        state_next = ST_PREP;
                end
            end
            ST_PREP:     state_next = ST_DIST_LO;
            ST_DIST_LO:  state_next = ST_DIST_HI;
            ST_DIST_HI:  state_next = ST_DIST_W;
            ST_DIST_W:   state_next = ST_DIST_CHG;
            ST_DIST_CHG:
            begin
                last_dist_next = scaled_dist;
                state_next     = ST_ROT_WAIT;
            end
            ST_ROT_WAIT:
            begin
                if (cor_done)
                    state_next = ST_X_LO;
            end
            ST_X_LO:     state_next = ST_X_HI;
            ST_X_HI:     state_next = ST_Y_LO;
            ST_Y_LO:     state_next = ST_Y_HI;
            ST_Y_HI:
            begin
                pos_x_next = sat_add(pos_x_reg, delta);
                state_next = ST_Y_WAIT;
            end
            ST_Y_WAIT:   state_next = ST_Y_DONE;
            ST_Y_DONE:
            begin
                pos_y_next = sat_add(pos_y_reg, delta);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            pos_x_reg          <= '0;
            pos_y_reg          <= '0;
            last_dist_reg      <= '0;
            heading_offset_reg <= '0;
            distance_scale_reg <= 16'd1180;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            last_dist_reg <= last_dist_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEADING_OFFSET: heading_offset_reg <= cfg_data;
                    CFG_DISTANCE_SCALE: distance_scale_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            left_reg  <= s_tdata[31:0];
            right_reg <= s_tdata[63:32];
            gyro_reg  <= s_tdata[80:64];
        end
        if (state_reg == ST_PREP)
        begin
            avg_reg  <= sum_lr[32:1];
            head_reg <= head_norm;
        end
        if (state_reg == ST_DIST_CHG)
            change_reg <= 33'(scaled_dist) - 33'(last_dist_reg);
        if (out_load)
        begin
            out_x_reg <= pos_x_reg;
            out_y_reg <= pos_y_reg;
        end
    end

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mul_op),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (acc)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .z_init  (z_init),
        .flip    (flip),
        .cos_out (cos_v),
        .sin_out (sin_v),
        .done    (cor_done)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

    `ODO_ASSERT_NEXT(a_pose_clear, s_accept && s_tuser[0],
        pos_x_reg == 0 && pos_y_reg == 0 && last_dist_reg == 0)
    `ODO_ASSERT_NEXT(a_calib_hold, s_accept && !s_tuser[0] && s_tuser[1],
        $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(last_dist_reg))
    `ODO_ASSERT_NOW(a_rot_ready, state_reg == ST_X_LO, cor_done)
    `ODO_ASSERT_NOW(a_dist_latency, state_reg == ST_DIST_CHG, $past(state_reg, 3) == ST_DIST_LO)

endmodule

// File: sim/odometry_tb_pkg.sv
package odometry_tb_pkg;

    typedef enum logic
    {
        REG_HEADING_OFFSET = 1'b0,
        REG_DISTANCE_SCALE = 1'b1
    } odo_reg_e;

    typedef enum logic
    {
        REQ_SAMPLE     = 1'b0,
        REQ_POSE_RESET = 1'b1
    } odo_req_e;

    typedef struct packed
    {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pose_t;

endpackage

// File: sim/odometry_pose_checker.sv
module odometry_pose_checker
    import odometry_tb_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,   // left_position_sum, right_position_sum, gyro_heading, pad
    input  logic [1:0]  s_tuser,   // req_type, calibrating
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // pose_x, pose_y
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          poses_checked
);

    localparam longint TURN = 92160;
    localparam longint UNIT_VECTOR_Q30 = 652032874;
    localparam int ROTATION_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    longint             arctan_q16 [0:23];
    logic [16:0]        heading_offset;
    logic [15:0]        distance_scale;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] last_distance;
    pose_t              expected_poses [$];

    // Arctangent of 2^-i in 2^-16 degree units, rounded to nearest.
    initial
    begin : arctan_fill
        int i;
        for (i = 0; i < 24; i++)
            arctan_q16[i] = longint'($rtoi($atan(2.0 ** (-i)) * 180.0 / 3.141592653589793
                                           * 65536.0 + 0.5));
    end

    function automatic logic signed [31:0] saturate(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint round_q30(input longint product);
        return (product + 64'sd536870912) >>> 30;
    endfunction

    function automatic void rotate_heading(input longint heading, output longint cosine,
                                           output longint sine);
        longint h;
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        int     i;
        h = heading;
        flip = 1'b0;
        cx = UNIT_VECTOR_Q30;
        cy = 0;
        if (h > TURN / 2)
            h = h - TURN;
        // Fold into [-90, 90] degrees; the half-turn is undone by negation.
        if (h > TURN / 4)
        begin
            h = h - TURN / 2;
            flip = 1'b1;
        end
        else if (h < -(TURN / 4))
        begin
            h = h + TURN / 2;
            flip = 1'b1;
        end
        z = h * 256;
        for (i = 0; i < ROTATION_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - arctan_q16[i];
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + arctan_q16[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        cosine = cx;
        sine = cy;
    endfunction

    function automatic void track_request(input logic [87:0] data, input logic [1:0] user);
        longint left;
        longint right;
        longint avg;
        longint scaled_dist;
        longint change;
        longint heading;
        longint cosine;
        longint sine;
        pose_t  pose;
        left = longint'($signed(data[31:0]));
        right = longint'($signed(data[63:32]));
        if (user[0] == REQ_POSE_RESET)
        begin
            pos_x = '0;
            pos_y = '0;
            last_distance = '0;
        end
        else if (!user[1])
        begin
            avg = (left + right) >>> 1;
            scaled_dist = (avg * longint'(distance_scale) + 64'sd32768) >>> 16;
            change = scaled_dist - longint'(last_distance);
            heading = (TURN - longint'(data[80:64]) + longint'(heading_offset)) % TURN;
            if (heading < 0)
                heading = heading + TURN;
            rotate_heading(heading, cosine, sine);
            pos_x = saturate(longint'(pos_x) + round_q30(change * cosine));
            pos_y = saturate(longint'(pos_y) + round_q30(change * sine));
            last_distance = saturate(scaled_dist);
        end
        pose.x = pos_x;
        pose.y = pos_y;
        expected_poses.push_back(pose);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pose_t want;
        pose_t got;
        if (!rst_n)
        begin
            heading_offset = '0;
            distance_scale = 16'd1180;
            pos_x = '0;
            pos_y = '0;
            last_distance = '0;
            expected_poses.delete();
            mismatches = 0;
            poses_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[31:0];
                got.y = m_tdata[63:32];
                if (expected_poses.size() == 0)
                begin
                    $display("%0t: pose transaction with none expected: x %0d y %0d",
                             $time, got.x, got.y);
                    mismatches++;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    poses_checked++;
                    if (got.x !== want.x)
                    begin
                        $display("%0t: pose_x expected %0d, got %0d", $time, want.x, got.x);
                        mismatches++;
                    end
                    if (got.y !== want.y)
                    begin
                        $display("%0t: pose_y expected %0d, got %0d", $time, want.y, got.y);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HEADING_OFFSET)
                    heading_offset = cfg_data;
                else if (cfg_index == REG_DISTANCE_SCALE)
                    distance_scale = cfg_data[15:0];
            end
            if (s_tvalid && s_tready)
                track_request(s_tdata, s_tuser);
            outstanding <= expected_poses.size();
        end
    end

endmodule

// File: sim/differential_drive_odometry_test.sv
module differential_drive_odometry_test;
    import odometry_tb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [16:0] cfg_data;

    int mismatches;
    int outstanding;
    int poses_checked;

    int send_idle_pct = 33;
    int recv_stall_pct = 33;
    bit hold_output = 1'b0;

    // Encoder and gyro tracks for well-formed motion.
    int odo_left = 0;
    int odo_right = 0;
    int gyro_track = 0;

    int n_samples = 0;
    int n_calibrating = 0;
    int n_resets = 0;
    int n_settings = 0;

    differential_drive_odometry u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    odometry_pose_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .poses_checked (poses_checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("differential_drive_odometry_test: errors");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input odo_req_e kind, input logic signed [31:0] left,
                                input logic signed [31:0] right, input logic [16:0] gyro,
                                input logic calib);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, gyro, right, left};
        s_tuser <= {calib, kind};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == REQ_POSE_RESET)
            n_resets++;
        else if (calib)
            n_calibrating++;
        else
            n_samples++;
    endtask

    task automatic random_request();
        int roll;
        int step_l;
        int step_r;
        roll = $urandom_range(99);
        if (roll < 5)
            send_request(REQ_POSE_RESET, $urandom, $urandom, 17'($urandom_range(131071)),
                         1'($urandom_range(1)));
        else if (roll < 14)
            send_request(REQ_SAMPLE, $urandom, $urandom, 17'($urandom_range(131071)), 1'b1);
        else if (roll < 26)
            send_request(REQ_SAMPLE, $urandom, $urandom, 17'($urandom_range(131071)), 1'b0);
        else
        begin
            // Smooth motion: both wheels move a little either way, heading drifts.
            step_l = int'($urandom_range(60000)) - 30000;
            step_r = step_l + int'($urandom_range(8000)) - 4000;
            odo_left = odo_left + step_l;
            odo_right = odo_right + step_r;
            gyro_track = (gyro_track + int'($urandom_range(2000)) - 1000 + 92160) % 92160;
            send_request(REQ_SAMPLE, odo_left, odo_right, 17'(gyro_track), 1'b0);
        end
    endtask

    // Stops offering and waits until every pose has come back.
    task automatic wait_for_poses();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [16:0] heading, input logic [15:0] scale);
        cfg_valid <= 1'b1;
        cfg_index <= REG_HEADING_OFFSET;
        cfg_data <= heading;
        do
            @(posedge clk);
        while (!cfg_ready);
        // The spare top bit of the data word must be ignored for the scale.
        cfg_index <= REG_DISTANCE_SCALE;
        cfg_data <= {1'($urandom_range(1)), scale};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial
    begin : stimulus
        int          p;
        int          n;
        logic [16:0] start_val;
        logic [15:0] scale_val;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEADING_OFFSET;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: headings around the circle,
        // wrap of out-of-range gyro values, extreme encoder sums, calibrating
        // skips and pose resets.
        send_request(REQ_SAMPLE, 32'sd0, 32'sd0, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sd256000, 32'sd256000, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sd512000, 32'sd512000, 17'd23040, 1'b0);
        send_request(REQ_SAMPLE, 32'sd768000, 32'sd768000, 17'd46080, 1'b0);
        send_request(REQ_SAMPLE, 32'sd1024000, 32'sd1024000, 17'd69120, 1'b0);
        send_request(REQ_SAMPLE, 32'sd1280000, 32'sd1280000, 17'd92159, 1'b0);
        send_request(REQ_SAMPLE, 32'sd1536000, 32'sd1536000, 17'd131071, 1'b0);
        send_request(REQ_SAMPLE, 32'sd1792000, 32'sd1000000, 17'd65536, 1'b0);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b1);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sh80000000, 32'sh80000000, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh80000000, 17'd11520, 1'b0);
        send_request(REQ_POSE_RESET, -32'sd1, -32'sd1, 17'd131071, 1'b1);
        send_request(REQ_SAMPLE, 32'sh10000000, 32'sh10000000, 17'd34560, 1'b0);
        send_request(REQ_POSE_RESET, 32'sd0, 32'sd0, 17'd0, 1'b0);

        // Largest scale and offset: full-range swings drive both saturations.
        wait_for_poses();
        write_settings(17'd131071, 16'd65535);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sh80000000, 32'sh80000000, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b0);
        send_request(REQ_SAMPLE, 32'sh80000000, 32'sh80000000, 17'd46080, 1'b0);
        send_request(REQ_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 17'd46080, 1'b0);
        send_request(REQ_SAMPLE, 32'sh80000000, 32'sh80000000, 17'd92160, 1'b0);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_for_poses();
            case (p)
                0: begin start_val = 17'd0;      scale_val = 16'd1180;  end
                1: begin start_val = 17'd92159;  scale_val = 16'd65535; end
                2: begin start_val = 17'd131071; scale_val = 16'd1;     end
                3: begin start_val = 17'($urandom_range(131071)); scale_val = 16'd0; end
                4: begin start_val = 17'd46080;  scale_val = 16'd65535; end
                5:
                begin
                    start_val = 17'($urandom_range(131071));
                    scale_val = 16'($urandom_range(65535));
                end
                default: begin start_val = 17'd23040; scale_val = 16'd1180; end
            endcase
            write_settings(start_val, scale_val);
            // One phase runs with both sides always ready.
            send_idle_pct = (p == 1) ? 0 : 33;
            recv_stall_pct = (p == 1) ? 0 : 33;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 10)
                    hold_output = 1'b1;
                random_request();
            end
        end

        wait_for_poses();
        $display("Covered %0d odometry samples, %0d calibrating skips and %0d pose resets",
                 n_samples, n_calibrating, n_resets);
        $display("under %0d register settings; %0d poses compared, %0d mismatches.",
                 n_settings + 1, poses_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("differential_drive_odometry_test: clean");
        else
            $display("differential_drive_odometry_test: errors");
        $finish;
    end

endmodule
